// ===== rtl/flvp_pkg.sv =====
// Shared types, constants and helpers for the FLV tag header parser.
package flvp_pkg;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_SKIP,
        PH_HDR,
        PH_PAY,
        PH_TRL,
        PH_DRAIN
    } t_phase;

    localparam logic [1:0] ST_TAG_OK    = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam int CountW = 24;

    localparam logic [CountW-1:0] SIG_LAST  = 24'd2;
    localparam logic [CountW-1:0] SKIP_LAST = 24'd9;
    localparam logic [CountW-1:0] HDR_LAST  = 24'd10;
    localparam logic [CountW-1:0] TRL_LAST  = 24'd3;

    localparam logic [7:0] TYPE_AUDIO = 8'd8;
    localparam logic [7:0] TYPE_VIDEO = 8'd9;
    localparam logic [3:0] FMT_AAC    = 4'd10;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_in_item;

    // First field in the lowest bits: tag_offset at [31:0].
    typedef struct packed {
        logic        [31:0] trailer_size;
        logic signed [23:0] composition_offset;
        logic        [7:0]  packet_kind;
        logic        [3:0]  low_nibble;
        logic        [3:0]  high_nibble;
        logic        [23:0] stream_ident;
        logic        [31:0] time_stamp;
        logic        [23:0] data_size;
        logic        [7:0]  tag_type;
        logic        [31:0] tag_offset;
    } t_result_data;

    typedef struct packed {
        logic [1:0]   status;
        t_result_data data;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h46;
            2'd1:    b = 8'h4C;
            2'd2:    b = 8'h56;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic codec_has_cts(input logic [3:0] codec);
        return (codec == 4'd7) || (codec == 4'd12) || (codec == 4'd13) ||
               (codec == 4'd14);
    endfunction

endpackage

// ===== rtl/flv_tag_header_parser.sv =====
// Top level of the FLV tag header parser: input register, parser, result register.
//
// Feed the FLV file one byte per item on the slave stream, with tlast on the
// last byte of the file. The block checks the "FLV" signature, skips the rest
// of the file header and the first previous-tag-size word, then walks the
// tags and sends one result item per complete tag, when the last byte of the
// tag's trailer arrives. A result carries the tag's file offset, type, size,
// timestamp, stream id, the decoded audio/video header nibbles, the AAC or
// video packet type and the signed composition time where the format has
// them, and the trailer word. tuser carries the status: 0 tag complete,
// 1 bad signature (all data zero, the rest of the file is dropped), 2 file
// ended inside a tag (fields not yet reached read zero, partly received ones
// hold their bytes in the low bits). After the tlast byte the parser re-arms
// for a new file. Rate: one byte per clock, sustained while the result
// register is free; each byte is held in the input register while the parse
// logic works on it, and the result register loads as the byte moves on, so a
// result item passes through the input register and then the result register.
// Backpressure on the master side holds the input register and then tready.
module flv_tag_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] tag_offset, [39:32] tag_type, [63:40] data_size,
    // [95:64] time_stamp, [119:96] stream_ident, [123:120] high_nibble,
    // [127:124] low_nibble, [135:128] packet_kind,
    // [159:136] composition_offset, [191:160] trailer_size
    output logic [191:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // [1:0] status
);
    import flvp_pkg::*;

    t_in_item in_item;
    t_in_item held_item;
    logic     held_vld;
    logic     out_free;
    logic     advance;
    logic     emit;
    t_result  core_result;
    t_result  out_result;

    assign in_item.data = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    // Advance the held byte whenever the result register can take a result.
    assign advance = held_vld && out_free;

    flvp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .i_item  (in_item),
        .o_rdy   (s_axis_tready),
        .i_take  (advance),
        .o_vld   (held_vld),
        .o_item  (held_item)
    );

    flvp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (advance),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (core_result)
    );

    flvp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (core_result),
        .i_rdy    (m_axis_tready),
        .o_free   (out_free),
        .o_vld    (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result.data;
    assign m_axis_tuser = out_result.status;

endmodule

// ===== rtl/flvp_in_stage.sv =====
// Input register of the FLV tag header parser.
module flvp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  flvp_pkg::t_in_item i_item,
    output logic              o_rdy,
    input  logic              i_take,
    output logic              o_vld,
    output flvp_pkg::t_in_item o_item
);
    import flvp_pkg::*;

    logic     r_vld;
    t_in_item r_item;

    // Free when empty or when the held item moves on this cycle.
    assign o_rdy  = !r_vld || i_take;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/flvp_core.sv =====
// Parse state and field capture of the FLV tag header parser.
module flvp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  flvp_pkg::t_in_item i_item,
    output logic               o_emit,
    output flvp_pkg::t_result  o_result
);
    import flvp_pkg::*;

    t_phase              r_phase, p_phase, n_phase;
    logic [CountW-1:0]   r_count, p_count, n_count;
    logic [31:0]         r_pos, n_pos;

    logic [31:0] r_offset, n_offset;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_size, n_size;
    logic [31:0] r_time, n_time;
    logic [23:0] r_stream, n_stream;
    logic [7:0]  r_hdr_byte, n_hdr_byte;
    logic [7:0]  r_pkt, n_pkt;
    logic [23:0] r_comp, n_comp;
    logic [31:0] r_trl, n_trl;

    logic [7:0]  b;
    logic        eos;
    logic        tag_start;
    logic        sig_bad;
    logic        trl_done;
    logic [CountW-1:0] pay_next;

    assign b         = i_item.data;
    assign eos       = i_item.last;
    assign tag_start = (r_phase == PH_HDR) && (r_count == '0);
    assign sig_bad   = (r_count > SIG_LAST) || (b != sig_byte(r_count[1:0]));
    assign trl_done  = (r_phase == PH_TRL) && (r_count == TRL_LAST);
    assign pay_next  = r_count + 1'b1;

    // Next state: phase and byte counter, then end of stream re-arms.
    always_comb begin
        p_phase = r_phase;
        p_count = r_count;
        case (r_phase)
            PH_SIG: begin
                if (sig_bad) begin
                    p_phase = PH_DRAIN;
                end else if (r_count == SIG_LAST) begin
                    p_phase = PH_SKIP;
                    p_count = '0;
                end else begin
                    p_count = r_count + 1'b1;
                end
            end
            PH_SKIP: begin
                if (r_count >= SKIP_LAST) begin
                    p_phase = PH_HDR;
                    p_count = '0;
                end else begin
                    p_count = r_count + 1'b1;
                end
            end
            PH_HDR: begin
                if (r_count >= HDR_LAST) begin
                    p_count = '0;
                    p_phase = (r_size != '0) ? PH_PAY : PH_TRL;
                end else begin
                    p_count = r_count + 1'b1;
                end
            end
            PH_PAY: begin
                if (pay_next == r_size) begin
                    p_phase = PH_TRL;
                    p_count = '0;
                end else begin
                    p_count = pay_next;
                end
            end
            PH_TRL: begin
                if (trl_done) begin
                    p_phase = PH_HDR;
                    p_count = '0;
                end else begin
                    p_count = r_count + 1'b1;
                end
            end
            default: begin
                p_phase = r_phase;
                p_count = r_count;
            end
        endcase

        n_phase = eos ? PH_SIG : p_phase;
        n_count = eos ? '0 : p_count;
        n_pos   = eos ? '0 : r_pos + 1'b1;
    end

    // Field capture and result.
    always_comb begin
        n_offset   = tag_start ? r_pos : r_offset;
        n_type     = tag_start ? '0 : r_type;
        n_size     = tag_start ? '0 : r_size;
        n_time     = tag_start ? '0 : r_time;
        n_stream   = tag_start ? '0 : r_stream;
        n_hdr_byte = tag_start ? '0 : r_hdr_byte;
        n_pkt      = tag_start ? '0 : r_pkt;
        n_comp     = tag_start ? '0 : r_comp;
        n_trl      = tag_start ? '0 : r_trl;

        case (r_phase)
            PH_HDR: begin
                if (r_count == 24'd0) begin
                    n_type = b;
                end else if (r_count <= 24'd3) begin
                    n_size = {r_size[15:0], b};
                end else if (r_count <= 24'd6) begin
                    n_time = {8'h00, r_time[15:0], b};
                end else if (r_count == 24'd7) begin
                    n_time = {b, r_time[23:0]};
                end else begin
                    n_stream = {r_stream[15:0], b};
                end
            end
            PH_PAY: begin
                if (r_type == TYPE_AUDIO) begin
                    if (r_count == 24'd0) begin
                        n_hdr_byte = b;
                    end else if (r_count == 24'd1 && r_hdr_byte[7:4] == FMT_AAC) begin
                        n_pkt = b;
                    end
                end else if (r_type == TYPE_VIDEO) begin
                    if (r_count == 24'd0) begin
                        n_hdr_byte = b;
                    end else if (codec_has_cts(r_hdr_byte[3:0])) begin
                        if (r_count == 24'd1) begin
                            n_pkt = b;
                        end else if (r_count <= 24'd4) begin
                            n_comp = {r_comp[15:0], b};
                        end
                    end
                end
            end
            PH_TRL: begin
                n_trl = {r_trl[23:0], b};
            end
            default: begin
                n_trl = n_trl;
            end
        endcase

        o_emit          = 1'b0;
        o_result.status = ST_TAG_OK;
        if (r_phase == PH_SIG && sig_bad) begin
            o_emit          = 1'b1;
            o_result.status = ST_BAD_SIG;
        end else if (trl_done) begin
            o_emit = 1'b1;
        end else if (eos) begin
            if (p_phase == PH_SIG) begin
                o_emit          = 1'b1;
                o_result.status = ST_BAD_SIG;
            end else if ((p_phase == PH_HDR && p_count != '0) ||
                         p_phase == PH_PAY || p_phase == PH_TRL) begin
                o_emit          = 1'b1;
                o_result.status = ST_TRUNCATED;
            end
        end

        o_result.data = '0;
        if (o_result.status != ST_BAD_SIG) begin
            o_result.data.tag_offset         = n_offset;
            o_result.data.tag_type           = n_type;
            o_result.data.data_size          = n_size;
            o_result.data.time_stamp         = n_time;
            o_result.data.stream_ident       = n_stream;
            if (n_type == TYPE_AUDIO || n_type == TYPE_VIDEO) begin
                o_result.data.high_nibble    = n_hdr_byte[7:4];
                o_result.data.low_nibble     = n_hdr_byte[3:0];
            end
            o_result.data.packet_kind        = n_pkt;
            o_result.data.composition_offset = n_comp;
            o_result.data.trailer_size       = n_trl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_vld) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    // Tag fields are cleared at each tag start, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_offset   <= n_offset;
            r_type     <= n_type;
            r_size     <= n_size;
            r_time     <= n_time;
            r_stream   <= n_stream;
            r_hdr_byte <= n_hdr_byte;
            r_pkt      <= n_pkt;
            r_comp     <= n_comp;
            r_trl      <= n_trl;
        end
    end

endmodule

// ===== rtl/flvp_out_stage.sv =====
// Result register of the FLV tag header parser.
module flvp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  flvp_pkg::t_result i_result,
    input  logic              i_rdy,
    output logic              o_free,
    output logic              o_vld,
    output flvp_pkg::t_result o_result
);
    import flvp_pkg::*;

    logic    r_vld;
    t_result r_result;

    assign o_free   = !r_vld || i_rdy;
    assign o_vld    = r_vld;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/flvp_checker.sv =====
// Port-level checks for the FLV tag header parser, bound to the top level.
module flvp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [7:0]   s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import flvp_pkg::*;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_TAG_OK || m_axis_tuser == ST_BAD_SIG ||
                           m_axis_tuser == ST_TRUNCATED))
        else $error("undefined status");

    a_bad_sig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_BAD_SIG |-> m_axis_tdata == '0)
        else $error("bad signature result carries data");

    a_nibbles_av: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[39:32] != TYPE_AUDIO &&
        m_axis_tdata[39:32] != TYPE_VIDEO |-> m_axis_tdata[127:120] == 8'h00)
        else $error("nibbles set on a tag that is neither audio nor video");

    a_cts_video: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[159:136] != 24'd0 |->
        m_axis_tdata[39:32] == TYPE_VIDEO)
        else $error("composition time on a non-video tag");

endmodule

bind flv_tag_header_parser flvp_checker u_flvp_checker (.*);

// ===== verif/flv_tb_pkg.sv =====
// Constants shared by the FLV tag header parser testbench files.
package flv_tb_pkg;

    localparam logic [23:0] FLV_MAGIC = "FLV";

    localparam logic [7:0] TYPE_SCRIPT = 8'd18;

    // Video codecs whose payload carries a packet type and a composition time
    localparam logic [3:0] CODEC_AVC  = 4'd7;
    localparam logic [3:0] CODEC_HEVC = 4'd12;
    localparam logic [3:0] CODEC_AV1  = 4'd13;
    localparam logic [3:0] CODEC_VP9  = 4'd14;

    localparam int SKIP_BYTES    = 10;
    localparam int TAG_HDR_BYTES = 11;
    localparam int TRAILER_BYTES = 4;

endpackage

// ===== verif/flv_tag_checker.sv =====
// Checker for the FLV tag header parser: predicts tag results and compares them.
module flv_tag_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output logic [31:0]  o_fail_count,
    output logic [31:0]  o_results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    import flvp_pkg::*;
    import flv_tb_pkg::*;

    t_phase       stage;
    logic [23:0]  step_cnt;
    logic [31:0]  file_pos;
    t_result_data asm_tag;     // tag being assembled, nibbles unused
    logic [7:0]   av_header;   // first payload byte of audio/video tags
    t_result      tag_results_due[$];
    int unsigned  mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic logic codec_with_cts(input logic [3:0] codec);
        return codec == CODEC_AVC || codec == CODEC_HEVC ||
               codec == CODEC_AV1 || codec == CODEC_VP9;
    endfunction

    function automatic t_result tag_result(input logic [1:0] status);
        t_result r;
        r = '0;
        r.status = status;
        if (status != ST_BAD_SIG) begin
            r.data = asm_tag;
            if (asm_tag.tag_type == TYPE_AUDIO || asm_tag.tag_type == TYPE_VIDEO) begin
                r.data.high_nibble = av_header[7:4];
                r.data.low_nibble  = av_header[3:0];
            end
        end
        return r;
    endfunction

    task automatic rearm();
        stage     = PH_SIG;
        step_cnt  = '0;
        file_pos  = '0;
        asm_tag   = '0;
        av_header = '0;
    endtask

    // Advance the parser model by one accepted byte; queue any result it yields.
    task automatic parse_flv_byte(input logic [7:0] b, input logic last);
        logic [31:0] at;
        logic        produced;
        int          idx;
        at       = file_pos;
        file_pos = file_pos + 1;
        produced = 1'b0;
        idx      = int'(step_cnt);
        case (stage)
            PH_SIG: begin
                if (idx > 2 || b != FLV_MAGIC[8*(2 - idx) +: 8]) begin
                    tag_results_due.push_back(tag_result(ST_BAD_SIG));
                    produced = 1'b1;
                    stage    = PH_DRAIN;
                end else begin
                    step_cnt = step_cnt + 1;
                    if (step_cnt == 3) begin
                        stage    = PH_SKIP;
                        step_cnt = '0;
                    end
                end
            end
            PH_SKIP: begin
                step_cnt = step_cnt + 1;
                if (step_cnt >= SKIP_BYTES) begin
                    stage    = PH_HDR;
                    step_cnt = '0;
                end
            end
            PH_HDR: begin
                if (idx == 0) begin
                    asm_tag            = '0;
                    av_header          = '0;
                    asm_tag.tag_offset = at;
                    asm_tag.tag_type   = b;
                end else if (idx <= 3) begin
                    asm_tag.data_size = {asm_tag.data_size[15:0], b};
                end else if (idx <= 6) begin
                    asm_tag.time_stamp[23:0] = {asm_tag.time_stamp[15:0], b};
                end else if (idx == 7) begin
                    asm_tag.time_stamp[31:24] = b;
                end else begin
                    asm_tag.stream_ident = {asm_tag.stream_ident[15:0], b};
                end
                step_cnt = step_cnt + 1;
                if (step_cnt >= TAG_HDR_BYTES) begin
                    step_cnt = '0;
                    stage    = (asm_tag.data_size != 0) ? PH_PAY : PH_TRL;
                end
            end
            PH_PAY: begin
                if (asm_tag.tag_type == TYPE_AUDIO) begin
                    if (idx == 0) begin
                        av_header = b;
                    end else if (idx == 1 && av_header[7:4] == FMT_AAC) begin
                        asm_tag.packet_kind = b;
                    end
                end else if (asm_tag.tag_type == TYPE_VIDEO) begin
                    if (idx == 0) begin
                        av_header = b;
                    end else if (codec_with_cts(av_header[3:0])) begin
                        if (idx == 1) begin
                            asm_tag.packet_kind = b;
                        end else if (idx <= 4) begin
                            asm_tag.composition_offset =
                                {asm_tag.composition_offset[15:0], b};
                        end
                    end
                end
                step_cnt = step_cnt + 1;
                if (step_cnt == asm_tag.data_size) begin
                    step_cnt = '0;
                    stage    = PH_TRL;
                end
            end
            PH_TRL: begin
                asm_tag.trailer_size = {asm_tag.trailer_size[23:0], b};
                step_cnt = step_cnt + 1;
                if (step_cnt >= TRAILER_BYTES) begin
                    tag_results_due.push_back(tag_result(ST_TAG_OK));
                    produced = 1'b1;
                    stage    = PH_HDR;
                    step_cnt = '0;
                end
            end
            default: ;
        endcase

        if (last) begin
            if (!produced) begin
                if (stage == PH_SIG) begin
                    tag_results_due.push_back(tag_result(ST_BAD_SIG));
                end else if ((stage == PH_HDR && step_cnt != 0) ||
                             stage == PH_PAY || stage == PH_TRL) begin
                    tag_results_due.push_back(tag_result(ST_TRUNCATED));
                end
            end
            rearm();
        end
    endtask

    task automatic match_field(input string label, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %0h, got %0h", $time, label, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result      want;
        t_result_data seen;
        if (!i_rst_n) begin
            rearm();
            tag_results_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_flv_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata;
                if (tag_results_due.size() == 0) begin
                    $display("%0t: result expected none, got status %0h offset %0h",
                             $time, m_axis_tuser, seen.tag_offset);
                    mismatches++;
                end else begin
                    want = tag_results_due.pop_front();
                    match_field("status", want.status, m_axis_tuser);
                    match_field("tag_offset", want.data.tag_offset, seen.tag_offset);
                    match_field("tag_type", want.data.tag_type, seen.tag_type);
                    match_field("data_size", want.data.data_size, seen.data_size);
                    match_field("time_stamp", want.data.time_stamp, seen.time_stamp);
                    match_field("stream_ident", want.data.stream_ident,
                                seen.stream_ident);
                    match_field("high_nibble", want.data.high_nibble, seen.high_nibble);
                    match_field("low_nibble", want.data.low_nibble, seen.low_nibble);
                    match_field("packet_kind", want.data.packet_kind, seen.packet_kind);
                    match_field("composition_offset", want.data.composition_offset,
                                seen.composition_offset);
                    match_field("trailer_size", want.data.trailer_size,
                                seen.trailer_size);
                end
            end
        end
        o_fail_count  <= mismatches;
        o_results_due <= tag_results_due.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the FLV tag header parser: byte stimulus, result stalls, verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import flvp_pkg::*;
    import flv_tb_pkg::*;

    localparam int RANDOM_ITEMS     = 800;
    localparam int PAYLOAD_CAP      = 40;      // longest payload actually sent
    localparam int LONG_HOLD_AFTER  = 20;      // results taken before the long hold-off
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 300_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;      // [7:0] data_byte
    logic         s_axis_tlast = 1'b0;    // end_of_stream
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] tag_offset, [39:32] tag_type, [63:40] data_size, [95:64] time_stamp,
    // [119:96] stream_ident, [123:120] high_nibble, [127:124] low_nibble,
    // [135:128] packet_kind, [159:136] composition_offset, [191:160] trailer_size
    logic [191:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;           // [1:0] status
    logic [31:0]  fail_count;
    logic [31:0]  results_due;

    logic [7:0]   file_bytes[$];          // file under construction
    int           items_sent = 0;
    int           burst_left = 0;
    bit           tx_offering = 1'b0;     // tvalid currently held high by the sender

    flv_tag_header_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    flv_tag_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Offer one item and hold it until taken; close the burst with a random gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        tx_offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Drop tvalid if the current burst left it raised.
    task automatic hold_tx();
        if (tx_offering) begin
            s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
        end
    endtask

    // Pause the sender until every predicted result has been taken.
    task automatic wait_drained();
        hold_tx();
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    // Send the file up to and including byte last_at, which carries tlast.
    task automatic send_file(input int last_at, input bit counted);
        for (int k = 0; k <= last_at; k++) send_byte(file_bytes[k], k == last_at);
        if (counted) items_sent += last_at + 1;
    endtask

    // Start a new file: signature, then the ten bytes the parser skips.
    task automatic put_file_head();
        file_bytes.delete();
        for (int k = 0; k < 3; k++) file_bytes.push_back(FLV_MAGIC[8*(2 - k) +: 8]);
        repeat (SKIP_BYTES) file_bytes.push_back(8'($urandom));
    endtask

    // Append one tag. Payload beyond PAYLOAD_CAP is not sent, and neither is the
    // trailer, so such a tag must end the file.
    task automatic add_tag(input logic [7:0] kind, input logic [23:0] size,
                           input logic [7:0] hdr, input logic [7:0] pkt,
                           input logic [23:0] cts, input logic [31:0] stamp,
                           input logic [23:0] sid, input logic [31:0] trl);
        logic [7:0] lead[5];
        int         stored;
        lead[0] = hdr;
        lead[1] = pkt;
        lead[2] = cts[23:16];
        lead[3] = cts[15:8];
        lead[4] = cts[7:0];
        stored  = (size > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(size);
        file_bytes.push_back(kind);
        for (int k = 2; k >= 0; k--) file_bytes.push_back(size[8*k +: 8]);
        for (int k = 2; k >= 0; k--) file_bytes.push_back(stamp[8*k +: 8]);
        file_bytes.push_back(stamp[31:24]);
        for (int k = 2; k >= 0; k--) file_bytes.push_back(sid[8*k +: 8]);
        for (int k = 0; k < stored; k++) begin
            file_bytes.push_back((k < 5) ? lead[k] : 8'($urandom));
        end
        if (size <= PAYLOAD_CAP) begin
            for (int k = 3; k >= 0; k--) file_bytes.push_back(trl[8*k +: 8]);
        end
    endtask

    // Append a tag of random content, biased toward audio and video headers.
    task automatic add_random_tag(input bit oversized);
        logic [7:0]  kind;
        logic [7:0]  hdr;
        logic [23:0] size;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = TYPE_AUDIO;
            4, 5, 6, 7: kind = TYPE_VIDEO;
            8:          kind = TYPE_SCRIPT;
            default:    kind = 8'($urandom);
        endcase
        hdr = 8'($urandom);
        if (kind == TYPE_AUDIO && $urandom_range(0, 1) == 1) hdr[7:4] = FMT_AAC;
        if (kind == TYPE_VIDEO && $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
                0:       hdr[3:0] = CODEC_AVC;
                1:       hdr[3:0] = CODEC_HEVC;
                2:       hdr[3:0] = CODEC_AV1;
                default: hdr[3:0] = CODEC_VP9;
            endcase
        end
        if (oversized) begin
            size = 24'($urandom_range(PAYLOAD_CAP + 1, 24'hFFFFFF));
        end else if ($urandom_range(0, 3) == 0) begin
            size = 24'($urandom_range(9, PAYLOAD_CAP));
        end else begin
            size = 24'($urandom_range(0, 8));
        end
        add_tag(kind, size, hdr, 8'($urandom), 24'($urandom), $urandom,
                24'($urandom), $urandom);
    endtask

    // Well-formed file with random tags; some end early, some on an oversized tag.
    task automatic random_file();
        int ntags;
        int ending;
        int last_at;
        put_file_head();
        ntags  = $urandom_range(1, 5);
        ending = $urandom_range(0, 9);
        for (int k = 0; k < ntags; k++) add_random_tag(ending == 9 && k == ntags - 1);
        last_at = file_bytes.size() - 1;
        if (ending == 7 || ending == 8) last_at = $urandom_range(0, last_at);
        send_file(last_at, 1'b1);
    endtask

    // Short run of junk, sometimes starting with a correct first signature byte.
    task automatic noise_file();
        int len;
        len = $urandom_range(1, 12);
        file_bytes.delete();
        repeat (len) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) file_bytes[0] = FLV_MAGIC[23:16];
        send_file(len - 1, 1'b1);
    endtask

    // Receiver: stall in random modes, plus one long hold-off so that the
    // parser backs up into its input.
    initial begin : result_sink
        int rx_seen;
        int hold_left;
        int mode;
        int mode_left;
        logic rdy;
        rx_seen   = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                rx_seen++;
                if (rx_seen == LONG_HOLD_AFTER) hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    initial begin : watchdog
        int unsigned cycle_cnt;
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bad signature on the third byte; the bytes after it are dropped.
        put_file_head();
        file_bytes[2] = 8'h00;
        send_file(4, 1'b1);

        // File ends inside the signature.
        put_file_head();
        send_file(0, 1'b1);

        // File ends inside the skipped bytes: nothing comes out.
        put_file_head();
        send_file(6, 1'b1);

        // Every tag flavor in one file, ending right after the last trailer.
        put_file_head();
        add_tag(TYPE_AUDIO, 24'd3, {FMT_AAC, 4'hF}, 8'h01, 24'h0, '1, '1, '1);
        add_tag(TYPE_VIDEO, 24'd7, {4'h1, CODEC_AVC}, 8'h01, 24'h800000, '0, '0, '0);
        add_tag(TYPE_VIDEO, 24'd2, 8'h22, 8'hFF, 24'h123456, 32'h01020304,
                24'h0A0B0C, 32'd13);
        add_tag(TYPE_SCRIPT, 24'd4, 8'h02, 8'h00, 24'h0, 32'h80000000, 24'h800000,
                32'd15);
        // empty payload goes straight to the trailer
        add_tag(TYPE_AUDIO, 24'd0, 8'hAF, 8'h01, 24'h0, 32'h7F, 24'h1, 32'd11);
        // short payload: composition time cut after its first byte
        add_tag(TYPE_VIDEO, 24'd3, {4'h2, CODEC_HEVC}, 8'h00, 24'h7FFFFF,
                32'h00FF00FF, 24'hFF00FF, 32'hFFFF0000);
        // short payload: AAC with no room for the packet type
        add_tag(TYPE_AUDIO, 24'd1, {FMT_AAC, 4'h0}, 8'h01, 24'h0, 32'd5, 24'd0, 32'd12);
        add_tag(8'hFF, 24'd5, 8'hFF, 8'hFF, 24'hFFFFFF, 32'd9, 24'd7, 32'd16);
        add_tag(TYPE_VIDEO, 24'd5, {4'hF, CODEC_VP9}, 8'h7F, 24'h7FFFFF, 32'd1,
                24'd2, 32'd16);
        send_file(file_bytes.size() - 1, 1'b1);

        // File ends partway through a tag header.
        put_file_head();
        add_tag(TYPE_VIDEO, 24'd6, {4'h1, CODEC_AV1}, 8'h01, 24'h000102, $urandom,
                24'($urandom), $urandom);
        send_file(3 + SKIP_BYTES + 5, 1'b1);

        // File ends inside the payload of an AAC tag.
        put_file_head();
        add_tag(TYPE_AUDIO, 24'd5, {FMT_AAC, 4'h3}, 8'h00, 24'h0, $urandom,
                24'($urandom), $urandom);
        send_file(3 + SKIP_BYTES + TAG_HDR_BYTES + 1, 1'b1);

        wait_drained();

        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 8) begin
                noise_file();
            end else begin
                random_file();
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/flvp_pkg.sv
rtl/flvp_in_stage.sv
rtl/flvp_core.sv
rtl/flvp_out_stage.sv
rtl/flv_tag_header_parser.sv
rtl/flvp_checker.sv
verif/flv_tb_pkg.sv
verif/flv_tag_checker.sv
verif/tb_top.sv
